// ===== hdl/i2c_register_access_master_defines.svh =====
// Assertion macros used by the checker file of the I2C register access master.
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH

// Concurrent assertion on clk that is switched off while rst is high.
`define I2CRAM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on clk that also holds during reset.
`define I2CRAM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/i2cram_pkg.sv =====
// Types and constants of the I2C register access master.
package i2cram_pkg;

  // Sequencer stages, one-hot.
  typedef enum logic [10:0] {
    STAGE_IDLE   = 11'b000_0000_0001,
    STAGE_START  = 11'b000_0000_0010,
    STAGE_DEVW   = 11'b000_0000_0100,
    STAGE_REG    = 11'b000_0000_1000,
    STAGE_DATA   = 11'b000_0001_0000,
    STAGE_RSTART = 11'b000_0010_0000,
    STAGE_DEVR   = 11'b000_0100_0000,
    STAGE_RECV   = 11'b000_1000_0000,
    STAGE_NACK   = 11'b001_0000_0000,
    STAGE_STOP   = 11'b010_0000_0000,
    STAGE_SETTLE = 11'b100_0000_0000
  } stage_t;

  // Configuration register indexes.
  localparam logic CFG_QUARTER_BIT_TICKS  = 1'b0;
  localparam logic CFG_WRITE_SETTLE_TICKS = 1'b1;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] QUARTER_BIT_TICKS_RESET  = 16'd125;
  localparam logic [19:0] WRITE_SETTLE_TICKS_RESET = 20'd0;

  // Bit counter value of the acknowledge slot.
  localparam logic [3:0] ACK_SLOT = 4'd8;
  // Last data bit before the acknowledge slot.
  localparam logic [3:0] LAST_DATA_BIT = 4'd7;

endpackage

// ===== hdl/i2c_register_access_master.sv =====
// I2C master that runs one register write or one register read per request.
//
//  channel | direction | handshake            | words
//  --------+-----------+----------------------+---------------------------------------
//  in      | input     | in_valid / in_ready  | request, operation, addresses, data, sda_in
//  out     | output    | out_valid / out_ready| scl_level, sda_release, busy_res, ...
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// Each input word is one tick of bus timing; its result word appears in the cycle after it
// is accepted, and a new word is taken every cycle while the output register is free
// or being read. The sequencer state and the output register form one stage.
// A stalled output register holds its word and blocks input; nothing else stalls.
// Reset (rst, synchronous) returns the sequencer to idle, so the first result word shows
// SCL and SDA released, and restores quarter_bit_ticks to 125 and write_settle_ticks to 0.
module i2c_register_access_master (
  input  logic        clk,
  input  logic        rst,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        request,
  input  logic        operation,
  input  logic [6:0]  device_address,
  input  logic [7:0]  register_address,
  input  logic [7:0]  write_data,
  input  logic        sda_in,
  // Output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_level,
  output logic        sda_release,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_data,
  output logic        no_ack,
  // Configuration port
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  // Configuration registers.
  logic [15:0] quarter_bit_ticks;
  logic [19:0] write_settle_ticks;

  // Sequencer state.
  i2cram_pkg::stage_t stage, stage_next;
  logic [1:0]  phase, phase_next;
  logic [19:0] tick_count, tick_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  received_byte, received_byte_next;
  logic        ack_missing, ack_missing_next;
  logic        req_op, req_op_next;
  logic [6:0]  req_dev, req_dev_next;
  logic [7:0]  req_reg, req_reg_next;
  logic [7:0]  req_data, req_data_next;

  // Per-tick working signals.
  logic        accept;
  logic        done_next;
  logic        scl_next;
  logic        sda_next;
  logic [15:0] qlen;
  logic [20:0] tick_inc;
  logic        quarter_last;
  logic        settle_last;
  logic        is_send;
  logic        is_send_next;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_bit_ticks  <= i2cram_pkg::QUARTER_BIT_TICKS_RESET;
      write_settle_ticks <= i2cram_pkg::WRITE_SETTLE_TICKS_RESET;
    end else if (cfg_write) begin
      if (cfg_index == i2cram_pkg::CFG_QUARTER_BIT_TICKS) begin
        quarter_bit_ticks <= cfg_data[15:0];
      end else begin
        write_settle_ticks <= cfg_data;
      end
    end
  end

  // Timing compares shared by the bit slots and the settle wait.
  always_comb begin
    qlen         = (quarter_bit_ticks == 16'd0) ? 16'd1 : quarter_bit_ticks;
    tick_inc     = {1'b0, tick_count} + 21'd1;
    quarter_last = tick_inc >= {5'd0, qlen};
    settle_last  = tick_inc >= {1'b0, write_settle_ticks};
    is_send      = (stage == i2cram_pkg::STAGE_DEVW) || (stage == i2cram_pkg::STAGE_REG) ||
                   (stage == i2cram_pkg::STAGE_DATA) || (stage == i2cram_pkg::STAGE_DEVR);
  end

  // Next state of the sequencer for one tick.
  always_comb begin
    stage_next         = stage;
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    received_byte_next = received_byte;
    ack_missing_next   = ack_missing;
    req_op_next        = req_op;
    req_dev_next       = req_dev;
    req_reg_next       = req_reg;
    req_data_next      = req_data;
    done_next          = 1'b0;

    unique case (stage)
      i2cram_pkg::STAGE_IDLE: begin
        if (request) begin
          req_op_next      = operation;
          req_dev_next     = device_address;
          req_reg_next     = register_address;
          req_data_next    = write_data;
          ack_missing_next = 1'b0;
          stage_next       = i2cram_pkg::STAGE_START;
          shift_byte_next  = 8'd0;
          bit_index_next   = 4'd0;
          phase_next       = 2'd0;
          tick_count_next  = 20'd0;
        end
      end

      i2cram_pkg::STAGE_SETTLE: begin
        if (settle_last) begin
          stage_next      = i2cram_pkg::STAGE_IDLE;
          shift_byte_next = 8'd0;
          bit_index_next  = 4'd0;
          phase_next      = 2'd0;
          tick_count_next = 20'd0;
          done_next       = 1'b1;
        end else begin
          tick_count_next = tick_inc[19:0];
        end
      end

      i2cram_pkg::STAGE_START, i2cram_pkg::STAGE_DEVW, i2cram_pkg::STAGE_REG,
      i2cram_pkg::STAGE_DATA, i2cram_pkg::STAGE_RSTART, i2cram_pkg::STAGE_DEVR,
      i2cram_pkg::STAGE_RECV, i2cram_pkg::STAGE_NACK, i2cram_pkg::STAGE_STOP: begin
        // Sample SDA on the last tick of the second quarter.
        if (quarter_last && phase == 2'd1) begin
          if (is_send && bit_index == i2cram_pkg::ACK_SLOT && sda_in) begin
            ack_missing_next = 1'b1;
          end
          if (stage == i2cram_pkg::STAGE_RECV && bit_index < i2cram_pkg::ACK_SLOT) begin
            shift_byte_next = {shift_byte[6:0], sda_in};
          end
        end

        if (!quarter_last) begin
          tick_count_next = tick_inc[19:0];
        end else if (phase != 2'd3) begin
          tick_count_next = 20'd0;
          phase_next      = 2'(phase + 2'd1);
        end else begin
          // End of a bit slot.
          tick_count_next = 20'd0;
          phase_next      = 2'd0;
          if (is_send && bit_index < i2cram_pkg::ACK_SLOT) begin
            shift_byte_next = {shift_byte[6:0], 1'b0};
            bit_index_next  = 4'(bit_index + 4'd1);
          end else if (stage == i2cram_pkg::STAGE_RECV &&
                       bit_index < i2cram_pkg::ACK_SLOT) begin
            bit_index_next = 4'(bit_index + 4'd1);
            if (bit_index == i2cram_pkg::LAST_DATA_BIT) begin
              received_byte_next = shift_byte;
              stage_next         = i2cram_pkg::STAGE_NACK;
              shift_byte_next    = 8'd0;
              bit_index_next     = 4'd0;
            end
          end else begin
            bit_index_next  = 4'd0;
            shift_byte_next = 8'd0;
            unique case (stage)
              i2cram_pkg::STAGE_START: begin
                stage_next      = i2cram_pkg::STAGE_DEVW;
                shift_byte_next = {req_dev, 1'b0};
              end
              i2cram_pkg::STAGE_DEVW: begin
                stage_next      = i2cram_pkg::STAGE_REG;
                shift_byte_next = req_reg;
              end
              i2cram_pkg::STAGE_REG: begin
                if (req_op == i2cram_pkg::OP_WRITE) begin
                  stage_next      = i2cram_pkg::STAGE_DATA;
                  shift_byte_next = req_data;
                end else begin
                  stage_next = i2cram_pkg::STAGE_RSTART;
                end
              end
              i2cram_pkg::STAGE_DATA: stage_next = i2cram_pkg::STAGE_STOP;
              i2cram_pkg::STAGE_RSTART: begin
                stage_next      = i2cram_pkg::STAGE_DEVR;
                shift_byte_next = {req_dev, 1'b1};
              end
              i2cram_pkg::STAGE_DEVR: stage_next = i2cram_pkg::STAGE_RECV;
              i2cram_pkg::STAGE_NACK: stage_next = i2cram_pkg::STAGE_STOP;
              i2cram_pkg::STAGE_STOP: begin
                if (req_op == i2cram_pkg::OP_WRITE && write_settle_ticks != 20'd0) begin
                  stage_next = i2cram_pkg::STAGE_SETTLE;
                end else begin
                  stage_next = i2cram_pkg::STAGE_IDLE;
                  done_next  = 1'b1;
                end
              end
              default: stage_next = i2cram_pkg::STAGE_IDLE;
            endcase
          end
        end
      end

      default: begin
        stage_next      = i2cram_pkg::STAGE_IDLE;
        shift_byte_next = 8'd0;
        bit_index_next  = 4'd0;
        phase_next      = 2'd0;
        tick_count_next = 20'd0;
      end
    endcase
  end

  // Bus drive for the state after this tick.
  always_comb begin
    is_send_next = (stage_next == i2cram_pkg::STAGE_DEVW) ||
                   (stage_next == i2cram_pkg::STAGE_REG) ||
                   (stage_next == i2cram_pkg::STAGE_DATA) ||
                   (stage_next == i2cram_pkg::STAGE_DEVR);
    scl_next = 1'b1;
    sda_next = 1'b1;
    if (stage_next == i2cram_pkg::STAGE_START) begin
      scl_next = (phase_next != 2'd3);
      sda_next = (phase_next < 2'd2);
    end else if (stage_next == i2cram_pkg::STAGE_RSTART) begin
      scl_next = (phase_next == 2'd1) || (phase_next == 2'd2);
      sda_next = (phase_next < 2'd2);
    end else if (stage_next == i2cram_pkg::STAGE_STOP) begin
      scl_next = (phase_next != 2'd0);
      sda_next = (phase_next >= 2'd2);
    end else if (is_send_next) begin
      scl_next = (phase_next == 2'd1) || (phase_next == 2'd2);
      sda_next = (bit_index_next < i2cram_pkg::ACK_SLOT) ? shift_byte_next[7] : 1'b1;
    end else if (stage_next == i2cram_pkg::STAGE_RECV ||
                 stage_next == i2cram_pkg::STAGE_NACK) begin
      scl_next = (phase_next == 2'd1) || (phase_next == 2'd2);
    end
  end

  // Sequencer registers advance once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= i2cram_pkg::STAGE_IDLE;
      phase         <= 2'd0;
      tick_count    <= 20'd0;
      bit_index     <= 4'd0;
      shift_byte    <= 8'd0;
      received_byte <= 8'd0;
      ack_missing   <= 1'b0;
      req_op        <= 1'b0;
      req_dev       <= 7'd0;
      req_reg       <= 8'd0;
      req_data      <= 8'd0;
    end else if (accept) begin
      stage         <= stage_next;
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      received_byte <= received_byte_next;
      ack_missing   <= ack_missing_next;
      req_op        <= req_op_next;
      req_dev       <= req_dev_next;
      req_reg       <= req_reg_next;
      req_data      <= req_data_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scl_level   <= scl_next;
      sda_release <= sda_next;
      busy_res    <= (stage_next != i2cram_pkg::STAGE_IDLE);
      done_res    <= done_next;
      read_data   <= received_byte_next;
      no_ack      <= ack_missing_next;
    end
  end

endmodule

// ===== hdl/i2cram_checker.sv =====
// Port-level checker of the I2C register access master and its bind.
`include "i2c_register_access_master_defines.svh"

module i2cram_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        scl_level,
  input logic        sda_release,
  input logic        busy_res,
  input logic        done_res,
  input logic [7:0]  read_data,
  input logic        no_ack
);

  // Reset empties the output register.
  `I2CRAM_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid, "output word survived reset")

  // Every accepted input word yields an output word in the next cycle.
  `I2CRAM_ASSERT(a_accept_to_out, in_valid && in_ready |=> out_valid, "result word missing")

  // A stalled output word blocks new input in that cycle and holds its payload.
  `I2CRAM_ASSERT(a_stall_holds, out_valid && !out_ready |-> !in_ready ##1 out_valid &&
    $stable(scl_level) && $stable(sda_release) && $stable(read_data) && $stable(no_ack),
    "stalled output word changed")

  // A done pulse only appears as the master returns to idle.
  `I2CRAM_ASSERT(a_done_idle, out_valid && done_res |-> !busy_res, "done while busy")

  // When idle the bus lines are released.
  `I2CRAM_ASSERT(a_idle_released, out_valid && !busy_res |-> scl_level && sda_release,
    "bus driven while idle")

endmodule

bind i2c_register_access_master i2cram_checker u_i2cram_checker (.*);

// ===== test/tb_top.sv =====
// Testbench for the I2C register access master: bus ticks checked against a tick-level predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cram_pkg::*;

  // One input word: the request fields plus the sampled SDA of this tick.
  typedef struct packed {
    logic       request;
    logic       operation;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_in;
  } tick_word_t;

  // One result word: line drive and status after the tick.
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_ack;
  } line_word_t;

  // How the simulated target drives SDA during an access.
  typedef enum logic [1:0] {SDA_SLAVE, SDA_LOW, SDA_HIGH, SDA_NOISE} sda_mode_t;

  // Bit slots of each access, counted from the start condition.
  localparam int WRITE_SLOTS     = 29;
  localparam int READ_SLOTS      = 39;
  localparam int DEV_ACK_SLOT    = 9;
  localparam int REG_ACK_SLOT    = 18;
  localparam int DATA_ACK_SLOT   = 27;
  localparam int DEVR_ACK_SLOT   = 28;
  localparam int RECV_FIRST_SLOT = 29;
  localparam int RANDOM_TICKS    = 850;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        request;
  logic        operation;
  logic [6:0]  device_address;
  logic [7:0]  register_address;
  logic [7:0]  write_data;
  logic        sda_in;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        scl_level;
  logic        sda_release;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_data;
  logic        no_ack;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_QUARTER_BIT_TICKS;
  logic [19:0] cfg_data = '0;

  tick_word_t  drive_word = '0;
  tick_word_t  tick_queue[$];
  line_word_t  expected_lines[$];
  logic        in_taken = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          gap_odds = 0;
  bit          calm = 1'b0;
  bit          long_hold = 1'b0;
  int          accepted_words = 0;
  int          queued_ticks = 0;
  int          error_count = 0;

  // Predictor copy of configuration and sequencer state.
  logic [15:0] quarter_len_cfg = QUARTER_BIT_TICKS_RESET;
  logic [19:0] settle_len_cfg = WRITE_SETTLE_TICKS_RESET;
  stage_t      bus_stage = STAGE_IDLE;
  logic [1:0]  quarter = '0;
  logic [19:0] tick_cnt = '0;
  logic [3:0]  bit_pos = '0;
  logic [7:0]  shifter = '0;
  logic        op_held = OP_WRITE;
  logic [6:0]  dev_held = '0;
  logic [7:0]  reg_held = '0;
  logic [7:0]  data_held = '0;
  logic [7:0]  rx_byte = '0;
  logic        ack_lost = 1'b0;

  assign {request, operation, device_address, register_address, write_data, sda_in} = drive_word;

  i2c_register_access_master dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic sending(stage_t s);
    return s == STAGE_DEVW || s == STAGE_REG || s == STAGE_DATA || s == STAGE_DEVR;
  endfunction

  function automatic void enter_stage(stage_t s, logic [7:0] first_byte);
    bus_stage = s;
    shifter = first_byte;
    bit_pos = '0;
    quarter = '0;
    tick_cnt = '0;
  endfunction

  // End of a four-quarter bit slot; returns 1 when the access completes here.
  function automatic logic finish_slot();
    if (sending(bus_stage) && bit_pos < ACK_SLOT) begin
      shifter = shifter << 1;
      bit_pos = bit_pos + 4'd1;
      return 1'b0;
    end
    if (bus_stage == STAGE_RECV && bit_pos < ACK_SLOT) begin
      bit_pos = bit_pos + 4'd1;
      if (bit_pos == ACK_SLOT) begin
        rx_byte = shifter;
        enter_stage(STAGE_NACK, 8'h00);
      end
      return 1'b0;
    end
    case (bus_stage)
      STAGE_START: enter_stage(STAGE_DEVW, {dev_held, OP_WRITE});
      STAGE_DEVW: enter_stage(STAGE_REG, reg_held);
      STAGE_REG: begin
        if (op_held == OP_WRITE) enter_stage(STAGE_DATA, data_held);
        else enter_stage(STAGE_RSTART, 8'h00);
      end
      STAGE_DATA: enter_stage(STAGE_STOP, 8'h00);
      STAGE_RSTART: enter_stage(STAGE_DEVR, {dev_held, OP_READ});
      STAGE_DEVR: enter_stage(STAGE_RECV, 8'h00);
      STAGE_NACK: enter_stage(STAGE_STOP, 8'h00);
      STAGE_STOP: begin
        if (op_held == OP_WRITE && settle_len_cfg != '0) begin
          enter_stage(STAGE_SETTLE, 8'h00);
          return 1'b0;
        end
        enter_stage(STAGE_IDLE, 8'h00);
        return 1'b1;
      end
      default: enter_stage(STAGE_IDLE, 8'h00);
    endcase
    return 1'b0;
  endfunction

  // Advances the sequencer by one tick and returns the line word it shows.
  function automatic line_word_t predict_lines(tick_word_t w);
    line_word_t r;
    logic       done;
    logic [20:0] qlen;
    logic       quarter_end;
    done = 1'b0;
    if (bus_stage == STAGE_IDLE) begin
      if (w.request) begin
        op_held = w.operation;
        dev_held = w.device_address;
        reg_held = w.register_address;
        data_held = w.write_data;
        ack_lost = 1'b0;
        enter_stage(STAGE_START, 8'h00);
      end
    end else if (bus_stage == STAGE_SETTLE) begin
      if ({1'b0, tick_cnt} + 21'd1 >= {1'b0, settle_len_cfg}) begin
        enter_stage(STAGE_IDLE, 8'h00);
        done = 1'b1;
      end else begin
        tick_cnt = tick_cnt + 20'd1;
      end
    end else begin
      // A zero quarter length behaves as one tick.
      qlen = (quarter_len_cfg == '0) ? 21'd1 : {5'd0, quarter_len_cfg};
      quarter_end = ({1'b0, tick_cnt} + 21'd1 >= qlen);
      if (quarter_end && quarter == 2'd1) begin
        if (sending(bus_stage) && bit_pos == ACK_SLOT && w.sda_in) ack_lost = 1'b1;
        if (bus_stage == STAGE_RECV && bit_pos < ACK_SLOT) shifter = {shifter[6:0], w.sda_in};
      end
      if (quarter_end) begin
        tick_cnt = '0;
        if (quarter == 2'd3) begin
          quarter = '0;
          done = finish_slot();
        end else begin
          quarter = quarter + 2'd1;
        end
      end else begin
        tick_cnt = tick_cnt + 20'd1;
      end
    end

    // Line drive follows the stage and quarter reached after the update.
    r.scl_level = 1'b1;
    r.sda_release = 1'b1;
    case (bus_stage)
      STAGE_START: begin
        r.scl_level = quarter < 2'd3;
        r.sda_release = quarter < 2'd2;
      end
      STAGE_RSTART: begin
        r.scl_level = quarter == 2'd1 || quarter == 2'd2;
        r.sda_release = quarter < 2'd2;
      end
      STAGE_STOP: begin
        r.scl_level = quarter >= 2'd1;
        r.sda_release = quarter >= 2'd2;
      end
      STAGE_DEVW, STAGE_REG, STAGE_DATA, STAGE_DEVR: begin
        r.scl_level = quarter == 2'd1 || quarter == 2'd2;
        r.sda_release = (bit_pos < ACK_SLOT) ? shifter[7] : 1'b1;
      end
      STAGE_RECV, STAGE_NACK: begin
        r.scl_level = quarter == 2'd1 || quarter == 2'd2;
      end
      default: ;
    endcase
    r.busy_res = bus_stage != STAGE_IDLE;
    r.done_res = done;
    r.read_data = rx_byte;
    r.no_ack = ack_lost;
    return r;
  endfunction

  function automatic void log_error(string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) log_error($sformatf("%s expected %h got %h", name, want, got));
  endfunction

  // Monitor: checks each result word and predicts each accepted input word.
  always @(posedge clk) begin : bus_monitor
    line_word_t got;
    line_word_t want;
    if (!rst && out_valid && out_ready) begin
      got = {scl_level, sda_release, busy_res, done_res, read_data, no_ack};
      if (expected_lines.size() == 0) begin
        log_error("result word with no tick waiting for it");
      end else begin
        want = expected_lines.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
        check_field("sda_release", 8'(want.sda_release), 8'(got.sda_release));
        check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        check_field("read_data", want.read_data, got.read_data);
        check_field("no_ack", 8'(want.no_ack), 8'(got.no_ack));
      end
    end
    if (!rst && in_valid && in_ready) begin
      expected_lines.push_back(predict_lines(drive_word));
      accepted_words++;
    end
    in_taken <= !rst && in_valid && in_ready;
  end

  // Driver: offers queued words, with random gaps between them.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (tick_queue.size() > 0 && !calm && $urandom_range(0, 15) < gap_odds) begin
      send_gap <= $urandom_range(1, 14) - 1;
      in_valid <= 1'b0;
    end else if (tick_queue.size() > 0) begin
      drive_word <= tick_queue.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off.
  always @(negedge clk) begin
    if (rst || long_hold) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) < gap_odds) begin
      recv_gap <= $urandom_range(1, 14) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Long receiver stall while the sender still has plenty of words queued.
  initial begin
    while (!(accepted_words > 300 && tick_queue.size() > 40)) @(posedge clk);
    long_hold = 1'b1;
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int quarter_eff();
    return (quarter_len_cfg == '0) ? 1 : int'(quarter_len_cfg);
  endfunction

  // Ticks for a complete access at the current settings, plus a little idle.
  function automatic int nominal_ticks(logic op);
    return quarter_eff() * 4 * ((op == OP_READ) ? READ_SLOTS : WRITE_SLOTS) +
           ((op == OP_WRITE) ? int'(settle_len_cfg) : 0) + 2;
  endfunction

  function automatic bit is_ack_slot(logic op, int slot);
    if (slot == DEV_ACK_SLOT || slot == REG_ACK_SLOT) return 1'b1;
    return (op == OP_WRITE) ? slot == DATA_ACK_SLOT : slot == DEVR_ACK_SLOT;
  endfunction

  // Queues one access: a request tick (when start is set) and the ticks that follow it.
  task automatic queue_access(input bit start, input logic op, input logic [6:0] dev,
                              input logic [7:0] reg_index, input logic [7:0] data,
                              input logic [7:0] reply, input sda_mode_t mode,
                              input bit flaky, input bit pokes, input int length);
    tick_word_t w;
    int         slot;
    w = {start, op, dev, reg_index, data, 1'b0};
    tick_queue.push_back(w);
    queued_ticks++;
    for (int k = 1; k < length; k++) begin
      slot = (k - 1) / (4 * quarter_eff());
      w = 26'($urandom);
      w.request = pokes && ($urandom_range(0, 7) == 0);
      case (mode)
        SDA_SLAVE: begin
          if (is_ack_slot(op, slot))
            w.sda_in = flaky && ($urandom_range(0, 7) == 0);
          else if (op == OP_READ && slot >= RECV_FIRST_SLOT && slot < RECV_FIRST_SLOT + 8)
            w.sda_in = reply[7 - (slot - RECV_FIRST_SLOT)];
        end
        SDA_LOW: w.sda_in = 1'b0;
        SDA_HIGH: w.sda_in = 1'b1;
        default: ;
      endcase
      tick_queue.push_back(w);
      queued_ticks++;
    end
  endtask

  // Waits until every queued word is accepted and every result has come back.
  task automatic drain();
    while (tick_queue.size() != 0 || in_valid || expected_lines.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [19:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_QUARTER_BIT_TICKS) quarter_len_cfg = value[15:0];
    else settle_len_cfg = value;
  endtask

  // Stimulus: directed accesses, then random ones under changing settings.
  initial begin
    int        target;
    int        phase;
    int        length;
    int        pick;
    logic      op;
    sda_mode_t mode;
    logic [15:0] q_set;
    logic [19:0] s_set;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    gap_odds = 2;

    // Reset timing: start a read on the slow bus, then finish it at zero quarter length.
    queue_access(1'b1, OP_READ, 7'h2A, 8'h3C, 8'h00, 8'h5A, SDA_SLAVE, 1'b0, 1'b0, 40);
    drain();
    write_register(CFG_QUARTER_BIT_TICKS, 20'd0);
    queue_access(1'b0, OP_READ, 7'h00, 8'h00, 8'h00, 8'h00, SDA_LOW, 1'b0, 1'b0,
                 nominal_ticks(OP_READ));

    // Field extremes, both operations, clean acknowledges.
    queue_access(1'b1, OP_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'h00, SDA_SLAVE, 1'b0, 1'b0,
                 nominal_ticks(OP_WRITE));
    queue_access(1'b1, OP_READ, 7'h00, 8'h00, 8'hFF, 8'h00, SDA_SLAVE, 1'b0, 1'b0,
                 nominal_ticks(OP_READ));
    drain();

    // Longest quarter: begin a write, then shorten the quarter to let it finish.
    write_register(CFG_QUARTER_BIT_TICKS, 20'hFFFFF);
    queue_access(1'b1, OP_WRITE, 7'h5A, 8'hA5, 8'h3C, 8'h00, SDA_SLAVE, 1'b0, 1'b0, 30);
    drain();
    write_register(CFG_QUARTER_BIT_TICKS, 20'd1);
    queue_access(1'b0, OP_WRITE, 7'h00, 8'h00, 8'h00, 8'h00, SDA_LOW, 1'b0, 1'b0,
                 nominal_ticks(OP_WRITE));
    drain();

    // Longest settle: park in the settle wait, then clear it to end the write.
    write_register(CFG_WRITE_SETTLE_TICKS, 20'hFFFFF);
    queue_access(1'b1, OP_WRITE, 7'h01, 8'h80, 8'h7E, 8'h00, SDA_SLAVE, 1'b0, 1'b0,
                 quarter_eff() * 4 * WRITE_SLOTS + 60);
    drain();
    write_register(CFG_WRITE_SETTLE_TICKS, 20'd0);
    queue_access(1'b0, OP_WRITE, 7'h00, 8'h00, 8'h00, 8'h00, SDA_LOW, 1'b0, 1'b0, 6);
    drain();

    // Random accesses, mostly well formed; each one runs under the next set of bus settings.
    target = queued_ticks + RANDOM_TICKS;
    phase = 0;
    while (queued_ticks < target) begin
      drain();
      case (phase % 5)
        0: begin q_set = 16'd1; s_set = 20'd0; end
        1: begin q_set = 16'd0; s_set = 20'd3; end
        2: begin q_set = 16'd2; s_set = 20'd0; end
        3: begin q_set = 16'd2; s_set = 20'd9; end
        default: begin q_set = 16'd1; s_set = 20'd1; end
      endcase
      phase++;
      write_register(CFG_QUARTER_BIT_TICKS, {4'd0, q_set});
      write_register(CFG_WRITE_SETTLE_TICKS, s_set);
      if (target - queued_ticks < 200) calm = 1'b1;
      gap_odds = calm ? 0 : $urandom_range(0, 4);
      op = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      mode = (pick < 7) ? SDA_SLAVE : (pick == 7) ? SDA_LOW : (pick == 8) ? SDA_HIGH : SDA_NOISE;
      length = nominal_ticks(op);
      // Some accesses are cut short so the next request lands while busy.
      if ($urandom_range(0, 5) == 0) length = $urandom_range(2, length);
      else length = length + $urandom_range(0, 12);
      queue_access(1'b1, op, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), mode,
                   $urandom_range(0, 1) == 1, mode == SDA_NOISE || $urandom_range(0, 7) == 0,
                   length);
    end

    calm = 1'b1;
    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_lines.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/i2cram_pkg.sv
hdl/i2c_register_access_master.sv
hdl/i2cram_checker.sv
test/tb_top.sv
